// ===== hw/rtl/brainfuck_machine_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the brainfuck machine core
// Concurrent assertion helpers that can be compiled out as a group.
// ----------------------------------------------------------------------------
`ifndef BRAINFUCK_MACHINE_CORE_DEFINES_SVH
`define BRAINFUCK_MACHINE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define BFM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfm assertion failed");
`define BFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfm assertion failed");
`else
`define BFM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BFM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/bfm_pkg.sv =====
// ----------------------------------------------------------------------------
// Brainfuck machine package
// Sizes, symbol and status codes, and request types shared by the core.
// ----------------------------------------------------------------------------
package bfm_pkg;

    localparam int CELL_COUNT    = 64;
    localparam int PROGRAM_DEPTH = 512;
    localparam int QUEUE_DEPTH   = 4;

    localparam int CELL_AW  = $clog2(CELL_COUNT);
    localparam int PROG_AW  = $clog2(PROGRAM_DEPTH);
    localparam int LEN_W    = $clog2(PROGRAM_DEPTH + 1);
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_STEP   = 2'd2;

    localparam logic [1:0] ST_RUNNING   = 2'd0;
    localparam logic [1:0] ST_FINISHED  = 2'd1;
    localparam logic [1:0] ST_UNMATCHED = 2'd2;

    localparam logic [7:0] SYM_PLUS  = 8'h2B;
    localparam logic [7:0] SYM_MINUS = 8'h2D;
    localparam logic [7:0] SYM_LEFT  = 8'h3C;
    localparam logic [7:0] SYM_RIGHT = 8'h3E;
    localparam logic [7:0] SYM_DOT   = 8'h2E;
    localparam logic [7:0] SYM_OPEN  = 8'h5B;
    localparam logic [7:0] SYM_CLOSE = 8'h5D;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_STEP
    } t_op;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] symbol;
    } t_in_req;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic [1:0] status;
    } t_out_rsp;

    typedef struct packed {
        t_op        op;
        logic [7:0] sym;
    } t_op_req;

endpackage

// ===== hw/rtl/bfm_front.sv =====
// ----------------------------------------------------------------------------
// Brainfuck machine front end
// Accepts requests, classifies them into operations and feeds the queue.
// ----------------------------------------------------------------------------
module bfm_front
    import bfm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_in_req i_in,
    output logic    o_in_stall,
    output logic    o_push,
    output t_op_req o_push_op,
    input  logic    i_q_full
);

    logic    r_valid;
    t_op_req r_op;

    assign o_in_stall = r_valid && i_q_full;
    assign o_push     = r_valid && !i_q_full;
    assign o_push_op  = r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (o_push) begin
                r_valid <= 1'b0;
            end
            if (i_in_valid && !o_in_stall) begin
                r_op.sym <= i_in.symbol;
                case (i_in.mode)
                    MODE_CLEAR: begin
                        r_valid   <= 1'b1;
                        r_op.op   <= OP_CLEAR;
                    end
                    MODE_APPEND: begin
                        r_valid   <= 1'b1;
                        r_op.op   <= OP_APPEND;
                    end
                    MODE_STEP: begin
                        r_valid   <= 1'b1;
                        r_op.op   <= OP_STEP;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// ===== hw/rtl/bfm_queue.sv =====
// ----------------------------------------------------------------------------
// Brainfuck machine operation queue
// Short first-in first-out buffer between the front end and the executor.
// ----------------------------------------------------------------------------
module bfm_queue
    import bfm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_op_req i_push_op,
    output logic    o_full,
    input  logic    i_pop,
    output t_op_req o_head,
    output logic    o_empty
);

    t_op_req               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/bfm_exec.sv =====
// ----------------------------------------------------------------------------
// Brainfuck machine executor
// Holds program and cell memories and carries out queued operations.
// ----------------------------------------------------------------------------
module bfm_exec
    import bfm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_op_valid,
    input  t_op_req  i_op,
    output logic     o_op_pop,
    output logic     o_out_valid,
    output t_out_rsp o_out,
    input  logic     i_out_stall
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_SCAN
    } t_state;

    t_state              r_state;
    logic [7:0]          r_prog_mem [PROGRAM_DEPTH];
    logic [7:0]          r_cell_mem [CELL_COUNT];
    logic [CELL_COUNT-1:0] r_cell_vld;
    logic [LEN_W-1:0]    r_len;
    logic [LEN_W-1:0]    r_ip;
    logic [LEN_W-1:0]    r_scan;
    logic [LEN_W-1:0]    r_depth;
    logic [CELL_AW-1:0]  r_dp;
    logic                r_fwd;
    logic [7:0]          r_prog_q;
    logic [7:0]          r_cell_q;
    logic                r_cell_hit;
    logic                r_out_valid;
    t_out_rsp            r_out;

    logic                out_free;
    logic                take_op;
    logic [7:0]          cell_val;
    logic [LEN_W-1:0]    ip_inc;
    logic [LEN_W-1:0]    ip_dec;
    logic [PROG_AW-1:0]  prog_raddr;
    logic                prog_wr;
    logic                cell_wr;
    logic [7:0]          cell_wdata;
    logic [LEN_W-1:0]    scan_next;
    logic                scan_end;
    logic                scan_inc;
    logic                scan_dec;
    logic                scan_match;
    logic [LEN_W-1:0]    depth_next;

    assign out_free = !r_out_valid || !i_out_stall;
    assign take_op  = (r_state == S_IDLE) && i_op_valid && ((i_op.op != OP_STEP) || out_free);
    assign o_op_pop = take_op;
    assign cell_val = r_cell_hit ? r_cell_q : 8'd0;
    assign ip_inc   = r_ip + 1'b1;
    assign ip_dec   = r_ip - 1'b1;

    assign prog_wr    = take_op && (i_op.op == OP_APPEND) && (r_len < LEN_W'(PROGRAM_DEPTH));
    assign cell_wr    = (r_state == S_FETCH) && ((r_prog_q == SYM_PLUS) || (r_prog_q == SYM_MINUS));
    assign cell_wdata = (r_prog_q == SYM_PLUS) ? cell_val + 8'd1 : cell_val - 8'd1;

    assign scan_next  = r_fwd ? r_scan + 1'b1 : r_scan - 1'b1;
    assign scan_end   = r_fwd ? (scan_next >= r_len) : (r_scan == '0);
    assign scan_inc   = r_fwd ? (r_prog_q == SYM_OPEN) : (r_prog_q == SYM_CLOSE);
    assign scan_dec   = r_fwd ? (r_prog_q == SYM_CLOSE) : (r_prog_q == SYM_OPEN);
    assign scan_match = scan_dec && (r_depth == '0);

    always_comb begin
        depth_next = r_depth;
        if (scan_inc) begin
            depth_next = r_depth + 1'b1;
        end else if (scan_dec) begin
            depth_next = r_depth - 1'b1;
        end
    end

    always_comb begin
        case (r_state)
            S_IDLE:  prog_raddr = r_ip[PROG_AW-1:0];
            S_FETCH: prog_raddr = (r_prog_q == SYM_OPEN) ? ip_inc[PROG_AW-1:0]
                                                         : ip_dec[PROG_AW-1:0];
            S_SCAN:  prog_raddr = scan_next[PROG_AW-1:0];
            default: prog_raddr = r_ip[PROG_AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (prog_wr) begin
            r_prog_mem[r_len[PROG_AW-1:0]] <= i_op.sym;
        end
        r_prog_q <= r_prog_mem[prog_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (cell_wr) begin
            r_cell_mem[r_dp] <= cell_wdata;
        end
        r_cell_q   <= r_cell_mem[r_dp];
        r_cell_hit <= r_cell_vld[r_dp];
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_ip        <= '0;
            r_dp        <= '0;
            r_cell_vld  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (take_op) begin
                        case (i_op.op)
                            OP_CLEAR: begin
                                r_len      <= '0;
                                r_ip       <= '0;
                                r_dp       <= '0;
                                r_cell_vld <= '0;
                            end
                            OP_APPEND: begin
                                if (prog_wr) begin
                                    r_len <= r_len + 1'b1;
                                end
                            end
                            OP_STEP: begin
                                if (r_ip < r_len) begin
                                    r_state <= S_FETCH;
                                end else begin
                                    r_out_valid <= 1'b1;
                                    r_out       <= '{1'b0, 8'd0, ST_FINISHED};
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_FETCH: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b1;
                    r_out       <= '{1'b0, 8'd0, ST_RUNNING};
                    r_ip        <= ip_inc;
                    case (r_prog_q)
                        SYM_PLUS, SYM_MINUS: begin
                            r_cell_vld[r_dp] <= 1'b1;
                        end
                        SYM_LEFT: begin
                            r_dp <= (r_dp == '0) ? CELL_AW'(CELL_COUNT - 1) : r_dp - 1'b1;
                        end
                        SYM_RIGHT: begin
                            r_dp <= (r_dp == CELL_AW'(CELL_COUNT - 1)) ? '0 : r_dp + 1'b1;
                        end
                        SYM_DOT: begin
                            r_out <= '{1'b1, cell_val, ST_RUNNING};
                        end
                        SYM_OPEN: begin
                            if (cell_val == 8'd0) begin
                                if (ip_inc < r_len) begin
                                    r_state     <= S_SCAN;
                                    r_out_valid <= 1'b0;
                                    r_ip        <= r_ip;
                                    r_scan      <= ip_inc;
                                    r_depth     <= '0;
                                    r_fwd       <= 1'b1;
                                end else begin
                                    r_ip  <= LEN_W'(1);
                                    r_out <= '{1'b0, 8'd0, ST_UNMATCHED};
                                end
                            end
                        end
                        SYM_CLOSE: begin
                            if (cell_val != 8'd0) begin
                                if (r_ip != '0) begin
                                    r_state     <= S_SCAN;
                                    r_out_valid <= 1'b0;
                                    r_ip        <= r_ip;
                                    r_scan      <= ip_dec;
                                    r_depth     <= '0;
                                    r_fwd       <= 1'b0;
                                end else begin
                                    r_ip  <= LEN_W'(1);
                                    r_out <= '{1'b0, 8'd0, ST_UNMATCHED};
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_SCAN: begin
                    if (scan_match) begin
                        r_state     <= S_IDLE;
                        r_ip        <= r_scan + 1'b1;
                        r_out_valid <= 1'b1;
                        r_out       <= '{1'b0, 8'd0, ST_RUNNING};
                    end else if (scan_end) begin
                        r_state     <= S_IDLE;
                        r_ip        <= LEN_W'(1);
                        r_out_valid <= 1'b1;
                        r_out       <= '{1'b0, 8'd0, ST_UNMATCHED};
                    end else begin
                        r_scan  <= scan_next;
                        r_depth <= depth_next;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/brainfuck_machine_core.sv =====
// ----------------------------------------------------------------------------
// Brainfuck machine core
// Program loader and single-step interpreter with a decoupled executor.
// ----------------------------------------------------------------------------
// Requests carry a mode and a symbol: clear empties the program and zeroes
// the cells, append stores one symbol, and step executes the symbol at the
// instruction pointer and returns exactly one response. Other modes are
// accepted and ignored. Requests pass a front stage and a four-entry queue,
// so input keeps flowing while the executor or the response side stalls
// until the queue fills. In the executor a clear or an append completes
// when it is taken, and a step first reads the program and cell memories
// and then executes. A bracket that jumps walks the program memory one
// symbol per cycle through its single registered read port. A step that
// finds the program finished responds straight from idle, without a memory
// read. No clearing pass is needed after reset.
`include "brainfuck_machine_core_defines.svh"

module brainfuck_machine_core
    import bfm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_req  i_in,
    output logic     o_in_stall,
    output logic     o_out_valid,
    output t_out_rsp o_out,
    input  logic     i_out_stall
);

    logic    q_push;
    t_op_req q_push_op;
    logic    q_full;
    logic    q_pop;
    t_op_req q_head;
    logic    q_empty;
    logic    emit_byte;

    assign emit_byte = o_out_valid && o_out.out_valid;

    bfm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .o_push     (q_push),
        .o_push_op  (q_push_op),
        .i_q_full   (q_full)
    );

    bfm_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (q_push),
        .i_push_op (q_push_op),
        .o_full    (q_full),
        .i_pop     (q_pop),
        .o_head    (q_head),
        .o_empty   (q_empty)
    );

    bfm_exec u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (!q_empty),
        .i_op        (q_head),
        .o_op_pop    (q_pop),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

    `BFM_ASSERT_IMP(a_pop_not_empty, i_clk, i_rst_n, q_pop, !q_empty)
    `BFM_ASSERT_IMP(a_push_not_full, i_clk, i_rst_n, q_push, !q_full)
    `BFM_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, q_push, !q_empty)
    `BFM_ASSERT_IMP(a_emit_running, i_clk, i_rst_n, emit_byte, o_out.status == ST_RUNNING)

endmodule

// ===== sim/brainfuck_machine_core_checker.sv =====
// ----------------------------------------------------------------------------
// Brainfuck machine core checker
// Watches both channels of the core. It interprets every accepted request
// on its own copy of the program, the cells and the pointers, and compares
// each accepted response with the oldest one it expects.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brainfuck_machine_core_checker
    import bfm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_req  i_in,
    input  logic     i_in_stall,
    input  logic     i_out_valid,
    input  t_out_rsp i_out,
    input  logic     i_out_stall,
    output int       o_fail_count,
    output int       o_pending
);

    logic [7:0]         prog_mem [PROGRAM_DEPTH];
    logic [7:0]         cell_mem [CELL_COUNT];
    int unsigned        prog_len;
    int unsigned        instr_ptr;
    logic [CELL_AW-1:0] data_ptr;
    t_out_rsp           expected_outputs [$];
    int                 failures = 0;
    int                 pending = 0;

    assign o_fail_count = failures;
    assign o_pending    = pending;

    function automatic void clear_machine();
        foreach (cell_mem[k]) begin
            cell_mem[k] = 8'h00;
        end
        prog_len  = 0;
        instr_ptr = 0;
        data_ptr  = '0;
    endfunction

    function automatic bit find_close_bracket(input int unsigned from,
                                              output int unsigned pos);
        int unsigned depth;
        int unsigned k;
        depth = 0;
        pos   = 0;
        for (k = from + 1; k < prog_len; k++) begin
            if (prog_mem[k] == SYM_OPEN) begin
                depth++;
            end else if (prog_mem[k] == SYM_CLOSE) begin
                if (depth == 0) begin
                    pos = k;
                    return 1'b1;
                end
                depth--;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit find_open_bracket(input int unsigned from,
                                             output int unsigned pos);
        int unsigned depth;
        int unsigned k;
        depth = 0;
        pos   = 0;
        k     = from;
        while (k > 0) begin
            k--;
            if (prog_mem[k] == SYM_CLOSE) begin
                depth++;
            end else if (prog_mem[k] == SYM_OPEN) begin
                if (depth == 0) begin
                    pos = k;
                    return 1'b1;
                end
                depth--;
            end
        end
        return 1'b0;
    endfunction

    function automatic void interpret_request(input t_in_req req);
        t_out_rsp    rsp;
        int unsigned next_ip;
        int unsigned match_pos;
        logic [7:0]  cur;
        rsp.out_valid = 1'b0;
        rsp.out_byte  = 8'h00;
        rsp.status    = ST_RUNNING;
        case (req.mode)
            MODE_CLEAR: begin
                clear_machine();
            end
            MODE_APPEND: begin
                if (prog_len < PROGRAM_DEPTH) begin
                    prog_mem[prog_len] = req.symbol;
                    prog_len++;
                end
            end
            MODE_STEP: begin
                if (instr_ptr >= prog_len) begin
                    rsp.status = ST_FINISHED;
                end else begin
                    cur     = prog_mem[instr_ptr];
                    next_ip = instr_ptr + 1;
                    case (cur)
                        SYM_PLUS:  cell_mem[data_ptr] = cell_mem[data_ptr] + 8'd1;
                        SYM_MINUS: cell_mem[data_ptr] = cell_mem[data_ptr] - 8'd1;
                        SYM_LEFT: begin
                            data_ptr = (data_ptr == 0) ? CELL_AW'(CELL_COUNT - 1)
                                                       : data_ptr - 1'b1;
                        end
                        SYM_RIGHT: begin
                            data_ptr = (data_ptr == CELL_AW'(CELL_COUNT - 1)) ? '0
                                                                              : data_ptr + 1'b1;
                        end
                        SYM_DOT: begin
                            rsp.out_valid = 1'b1;
                            rsp.out_byte  = cell_mem[data_ptr];
                        end
                        SYM_OPEN: begin
                            if (cell_mem[data_ptr] == 8'h00) begin
                                if (find_close_bracket(instr_ptr, match_pos)) begin
                                    next_ip = match_pos + 1;
                                end else begin
                                    next_ip    = 1;
                                    rsp.status = ST_UNMATCHED;
                                end
                            end
                        end
                        SYM_CLOSE: begin
                            if (cell_mem[data_ptr] != 8'h00) begin
                                if (find_open_bracket(instr_ptr, match_pos)) begin
                                    next_ip = match_pos + 1;
                                end else begin
                                    next_ip    = 1;
                                    rsp.status = ST_UNMATCHED;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    instr_ptr = next_ip;
                end
                expected_outputs.push_back(rsp);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void log_failure(input string what, input t_out_rsp want,
                                        input t_out_rsp got);
        failures++;
        if (failures <= 10) begin
            $display("%0t: %s: expected valid %0d byte %02h status %0d,",
                     $time, what, want.out_valid, want.out_byte, want.status);
            $display("    got valid %0d byte %02h status %0d",
                     got.out_valid, got.out_byte, got.status);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_rsp want;
        if (!i_rst_n) begin
            clear_machine();
            expected_outputs.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                interpret_request(i_in);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_outputs.size() == 0) begin
                    log_failure("response with none expected", '0, i_out);
                end else begin
                    want = expected_outputs.pop_front();
                    if (i_out.out_valid !== want.out_valid || i_out.out_byte !== want.out_byte
                            || i_out.status !== want.status) begin
                        log_failure("response mismatch", want, i_out);
                    end
                end
            end
        end
        pending <= expected_outputs.size();
    end

endmodule

// ===== sim/brainfuck_machine_core_test.sv =====
// ----------------------------------------------------------------------------
// Brainfuck machine core testbench
// Loads short programs into the core and single-steps them with random
// gaps on the request side and random stalls on the response side. A
// directed opening covers wrapping cells and pointers, output, matched and
// unmatched brackets, unused modes and steps past the end; a checker beside
// the core predicts and compares every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brainfuck_machine_core_test;

    import bfm_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         ITEM_TARGET = 1850;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    t_in_req  in_req = '0;
    logic     in_stall;
    logic     out_valid;
    t_out_rsp out_rsp;
    logic     out_stall = 1'b0;
    int       fail_count;
    int       pending;
    int       sent_count = 0;
    bit       send_calm = 1'b0;
    bit       recv_calm = 1'b0;

    brainfuck_machine_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in        (in_req),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out       (out_rsp),
        .i_out_stall (out_stall)
    );

    brainfuck_machine_core_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in         (in_req),
        .i_in_stall   (in_stall),
        .i_out_valid  (out_valid),
        .i_out        (out_rsp),
        .i_out_stall  (out_stall),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_request(input logic [1:0] mode, input logic [7:0] sym);
        int unsigned gap;
        t_in_req     req;
        gap        = send_calm ? 0 : $urandom_range(0, 5);
        req.mode   = mode;
        req.symbol = sym;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        do @(posedge clk); while (in_stall);
        if (mode != MODE_UNUSED) begin
            sent_count++;
        end
    endtask

    task automatic append_text(input string text);
        int k;
        for (k = 0; k < text.len(); k++) begin
            send_request(MODE_APPEND, text[k]);
        end
    endtask

    task automatic run_steps(input int unsigned count, input bit noisy);
        int unsigned k;
        for (k = 0; k < count; k++) begin
            if (noisy && $urandom_range(0, 29) == 0) begin
                send_request(MODE_UNUSED, 8'($urandom_range(0, 255)));
            end
            if (noisy && $urandom_range(0, 39) == 0) begin
                send_request(MODE_APPEND, 8'($urandom_range(0, 255)));
            end
            send_request(MODE_STEP, 8'($urandom_range(0, 255)));
        end
    endtask

    // Mostly commands with balanced brackets; a few raw bytes and, when not
    // closed, open loops make broken programs.
    task automatic append_random_program(input int unsigned len, input bit closed);
        int unsigned depth;
        int unsigned pick;
        int unsigned k;
        logic [7:0]  sym;
        depth = 0;
        for (k = 0; k < len; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                sym = SYM_PLUS;
            end else if (pick < 35) begin
                sym = SYM_MINUS;
            end else if (pick < 45) begin
                sym = SYM_LEFT;
            end else if (pick < 55) begin
                sym = SYM_RIGHT;
            end else if (pick < 70) begin
                sym = SYM_DOT;
            end else if (pick < 82) begin
                sym = SYM_OPEN;
                depth++;
            end else if (pick < 95 && depth != 0) begin
                sym = SYM_CLOSE;
                depth--;
            end else begin
                sym = 8'($urandom_range(0, 255));
            end
            send_request(MODE_APPEND, sym);
        end
        while (closed && depth != 0) begin
            send_request(MODE_APPEND, SYM_CLOSE);
            depth--;
        end
    endtask

    initial begin
        int unsigned len;
        bit          filled_once;
        filled_once = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_request(MODE_CLEAR, 8'h00);
        send_request(MODE_STEP, 8'hFF);
        send_request(MODE_UNUSED, 8'hFF);
        send_request(MODE_APPEND, 8'h00);
        send_request(MODE_APPEND, 8'hFF);
        append_text("-.<.[");
        run_steps(7, 1'b0);
        send_request(MODE_CLEAR, 8'hFF);
        append_text("[]+]");
        run_steps(5, 1'b0);

        while (sent_count < ITEM_TARGET) begin
            send_calm = ($urandom_range(0, 3) == 0);
            if (!filled_once && sent_count > 800) begin
                // The program overflows the store, and its leading bracket
                // scans across the whole of it.
                send_request(MODE_CLEAR, 8'($urandom_range(0, 255)));
                send_request(MODE_APPEND, SYM_OPEN);
                append_random_program(PROGRAM_DEPTH + 3, 1'b1);
                run_steps(40, 1'b0);
                filled_once = 1'b1;
            end else begin
                if ($urandom_range(0, 7) != 0) begin
                    send_request(MODE_CLEAR, 8'($urandom_range(0, 255)));
                end
                len = $urandom_range(1, 24);
                append_random_program(len, $urandom_range(0, 5) != 0);
                run_steps($urandom_range(len, 3 * len + 8), 1'b1);
            end
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (40) @(posedge clk);
        if (fail_count == 0) begin
            $display("brainfuck_machine_core test passed");
        end else begin
            $display("brainfuck_machine_core test failed");
        end
        $finish;
    end

    // Response side. Two long hold-offs let the core fill up and stall its
    // request input.
    initial begin
        int unsigned wait_cycles;
        int unsigned got;
        got = 0;
        wait (rst_n);
        forever begin
            if (got % 50 == 0) begin
                recv_calm = ($urandom_range(0, 3) == 0);
            end
            if (got == 150 || got == 700) begin
                wait_cycles = 300;
            end else if (recv_calm) begin
                wait_cycles = 0;
            end else begin
                wait_cycles = $urandom_range(0, 5);
            end
            if (wait_cycles != 0) begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            got++;
        end
    end

    initial begin
        #5000000;
        $display("brainfuck_machine_core test failed");
        $finish;
    end

endmodule
